FILE: hdl/pfps_pkg.sv
// Shared types, widths and codes for the playback frame position stepper.
// Used by the shared divider unit and by the top-level sequencer.
package pfps_pkg;

    // Block constants
    localparam int FRAME_BITS   = 24;
    localparam int DEFAULT_RATE = 60;

    // Field widths
    localparam int POS_W   = 24;
    localparam int START_W = 24;
    localparam int LEN_W   = 25;
    localparam int RATE_W  = 17;
    localparam int SRC_W   = 16;
    localparam int SEEK_W  = 25;
    localparam int JUMP_W  = 24;
    localparam int FUNC_W  = 2;

    // Internal arithmetic widths
    localparam int PH_W   = 17;                     // phase counter, signed
    localparam int SUM_W  = PH_W + 1;               // phase + rate
    localparam int DLT_W  = SEEK_W + 1;             // frame step, signed
    localparam int NXT_W  = ((FRAME_BITS > LEN_W) ? FRAME_BITS : LEN_W) + 2;
    localparam int END_W  = LEN_W + 1;              // start + length
    localparam int DIV_W  = NXT_W - 1;              // divider operand width
    localparam int CNT_W  = $clog2(DIV_W + 1);

    // Port widths
    localparam int IDX_W       = 3;
    localparam int CFG_W       = 25;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_WIN_START = 3'd0;
    localparam logic [IDX_W-1:0] REG_WIN_LEN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOOP      = 3'd2;
    localparam logic [IDX_W-1:0] REG_PLAY_RATE = 3'd3;
    localparam logic [IDX_W-1:0] REG_SRC_RATE  = 3'd4;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FN_TICK = 2'd0,
        FN_SEEK = 2'd1,
        FN_JUMP = 2'd2,
        FN_NONE = 2'd3
    } t_func;

    // Divider control and status
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

FILE: hdl/pfps_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on pfps_pkg for widths and the control/status structs.
module pfps_div import pfps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctl         i_ctl,
    input  logic [DIV_W-1:0] i_dividend,   // MSB-aligned, top i_ctl.count bits used
    input  logic [DIV_W-1:0] i_divisor,
    output t_div_sts         o_sts,
    output logic [DIV_W-1:0] o_quot,       // quotient in low i_ctl.count bits
    output logic [DIV_W-1:0] o_rem
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [DIV_W-1:0] r_dvd, n_dvd;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_div;

    logic [DIV_W+1:0] w_trial;
    logic             w_fit;

    // One trial subtract per cycle
    always_comb begin
        w_trial = {1'b0, r_rem, r_dvd[DIV_W-1]} - {2'b00, r_div};
        w_fit   = ~w_trial[DIV_W+1];
    end

    // Iteration control
    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        if (i_ctl.start) begin
            n_cnt = i_ctl.count;
            n_dvd = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
            n_dvd  = {r_dvd[DIV_W-2:0], w_fit};
            n_rem  = w_fit ? w_trial[DIV_W-1:0] : {r_rem[DIV_W-2:0], r_dvd[DIV_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (i_ctl.start) begin
            r_div <= i_divisor;
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_quot     = r_dvd;
    assign o_rem      = r_rem;

    // Checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !o_sts.busy)
        else $error("divider started while busy");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |=> !o_sts.done)
        else $error("divider done held longer than one cycle");

endmodule

FILE: hdl/playback_frame_position_stepper_top.sv
// Top level of the playback frame position stepper: config registers,
// item sequencer and output register. Depends on pfps_pkg and pfps_div.
//
// Steps the displayed frame of a clip inside [window_start, window_start +
// window_length). One item is worked at a time; s_axis_tready is high only
// while the sequencer is idle, and a finished result waits in the output
// register so the next item can be taken before it is read. All division goes
// through one shared bit-serial divider: a tick runs the rate division (17
// quotient bits) and a wrap adds the window modulo (26 bits). An absolute jump
// or the unused code goes straight to write-back, a relative seek skips the
// rate division, and write-back waits while the output register stays full.
// The next item can be accepted in the cycle after the result is written.
// Configuration may be written any time the block is idle; the write port is
// always ready.
module playback_frame_position_stepper_top import pfps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [24:0] seek_delta, [48:25] jump_frame
    input  logic [FUNC_W-1:0]    s_axis_tuser,   // [1:0] func
    // Result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [23:0] frame_position
    output logic [M_TUSER_W-1:0] m_axis_tuser    // [0] go_live, [1] moved
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PDIV   = 6'b000010,
        S_ADD    = 6'b000100,
        S_DECIDE = 6'b001000,
        S_MOD    = 6'b010000,
        S_WB     = 6'b100000
    } t_state;

    // Configuration registers
    logic [START_W-1:0]    r_win_start;
    logic [LEN_W-1:0]      r_win_len;
    logic                  r_loop;
    logic [RATE_W-1:0]     r_play_rate;
    logic [SRC_W-1:0]      r_src_rate;

    // Sequencer and state
    t_state                r_state, n_state;
    logic [FRAME_BITS-1:0] r_pos, n_pos;
    logic [PH_W-1:0]       r_phase, n_phase;
    logic [DLT_W-1:0]      r_delta, n_delta;
    logic                  r_neg, n_neg;
    logic [NXT_W-1:0]      r_next, n_next;
    logic [END_W-1:0]      r_end, n_end;
    logic                  r_bwd, n_bwd;
    logic                  r_live, n_live;
    logic                  r_moved, n_moved;

    // Output register
    logic                  r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]  r_out_pos, n_out_pos;
    logic                  r_out_live, n_out_live;
    logic                  r_out_moved, n_out_moved;

    // Divider hookup
    t_div_ctl              w_div_ctl;
    t_div_sts              w_div_sts;
    logic [DIV_W-1:0]      w_div_dvd, w_div_dsr, w_quot, w_rem;

    // Combinational helpers
    logic                  w_accept;
    t_func                 w_func;
    logic [SEEK_W-1:0]     w_seek;
    logic [JUMP_W-1:0]     w_jump;
    logic [SRC_W-1:0]      w_rate;
    logic [SUM_W-1:0]      w_sum, w_mag_full;
    logic [PH_W-1:0]       w_mag, w_q, w_r;
    logic [DLT_W-1:0]      w_qx;
    logic [NXT_W-1:0]      w_pos_x, w_dlt_x, w_end_x, w_start_x;
    logic [NXT_W-1:0]      w_fwd_dvd, w_bwd_dvd;
    logic [DIV_W-1:0]      w_fwd_pos, w_bwd_pos;
    logic                  w_cfg_we;

    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= '0;
            r_win_len   <= '0;
            r_loop      <= 1'b1;
            r_play_rate <= '0;
            r_src_rate  <= '0;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIN_START: r_win_start <= i_cfg_data[START_W-1:0];
                REG_WIN_LEN:   r_win_len   <= i_cfg_data[LEN_W-1:0];
                REG_LOOP:      r_loop      <= i_cfg_data[0];
                REG_PLAY_RATE: r_play_rate <= i_cfg_data[RATE_W-1:0];
                REG_SRC_RATE:  r_src_rate  <= i_cfg_data[SRC_W-1:0];
                default: ;
            endcase
        end
    end

    // Input unpacking and tick arithmetic
    always_comb begin
        w_accept   = s_axis_tvalid & s_axis_tready;
        w_func     = t_func'(s_axis_tuser);
        w_seek     = s_axis_tdata[SEEK_W-1:0];
        w_jump     = s_axis_tdata[SEEK_W+JUMP_W-1:SEEK_W];
        w_rate     = (r_src_rate != '0) ? r_src_rate : SRC_W'(DEFAULT_RATE);
        w_sum      = {r_phase[PH_W-1], r_phase} + {r_play_rate[RATE_W-1], r_play_rate};
        w_mag_full = w_sum[SUM_W-1] ? (SUM_W'(0) - w_sum) : w_sum;
        w_mag      = w_mag_full[PH_W-1:0];
        w_q        = w_quot[PH_W-1:0];
        w_r        = w_rem[PH_W-1:0];
        w_qx       = {{(DLT_W-PH_W){1'b0}}, w_q};
        w_pos_x    = NXT_W'(r_pos);
        w_dlt_x    = {{(NXT_W-DLT_W){r_delta[DLT_W-1]}}, r_delta};
        w_end_x    = NXT_W'(r_end);
        w_start_x  = NXT_W'(r_win_start);
        w_fwd_dvd  = r_next - w_start_x;
        w_bwd_dvd  = w_start_x - r_next;
        w_fwd_pos  = w_rem + DIV_W'(r_win_start);
        w_bwd_pos  = DIV_W'(r_end) - w_rem;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_delta     = r_delta;
        n_neg       = r_neg;
        n_next      = r_next;
        n_end       = r_end;
        n_bwd       = r_bwd;
        n_live      = r_live;
        n_moved     = r_moved;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_pos   = r_out_pos;
        n_out_live  = r_out_live;
        n_out_moved = r_out_moved;
        w_div_ctl   = '0;
        w_div_dvd   = '0;
        w_div_dsr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_live  = 1'b0;
                    n_moved = 1'b0;
                    unique case (w_func)
                        FN_TICK: begin
                            // |phase + play_rate| / source rate, MSB-aligned in the divider
                            n_neg           = w_sum[SUM_W-1];
                            w_div_ctl.start = 1'b1;
                            w_div_ctl.count = CNT_W'(PH_W);
                            w_div_dvd       = {w_mag, {(DIV_W-PH_W){1'b0}}};
                            w_div_dsr       = DIV_W'(w_rate);
                            n_state         = S_PDIV;
                        end
                        FN_SEEK: begin
                            n_delta = {w_seek[SEEK_W-1], w_seek};
                            n_state = S_ADD;
                        end
                        FN_JUMP: begin
                            n_pos   = FRAME_BITS'(w_jump);
                            n_phase = '0;
                            n_moved = (r_win_len != '0);
                            n_state = S_WB;
                        end
                        default: begin
                            n_state = S_WB;
                        end
                    endcase
                end
            end
            S_PDIV: begin
                // Signs follow the dividend: truncation toward zero
                if (w_div_sts.done) begin
                    n_phase = r_neg ? (PH_W'(0) - w_r) : w_r;
                    n_delta = r_neg ? (DLT_W'(0) - w_qx) : w_qx;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_next  = w_pos_x + w_dlt_x;
                n_end   = END_W'(r_win_start) + END_W'(r_win_len);
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_WB;
                if (r_win_len != '0) begin
                    n_moved = 1'b1;
                    if (!r_delta[DLT_W-1] && (r_delta != '0)) begin
                        // Forward step
                        if ($signed(r_next) < $signed(w_end_x)) begin
                            n_pos = r_next[FRAME_BITS-1:0];
                        end else if (r_loop) begin
                            w_div_ctl.start = 1'b1;
                            w_div_ctl.count = CNT_W'(DIV_W);
                            w_div_dvd       = w_fwd_dvd[DIV_W-1:0];
                            w_div_dsr       = DIV_W'(r_win_len);
                            n_bwd           = 1'b0;
                            n_state         = S_MOD;
                        end else begin
                            n_live = 1'b1;
                            n_pos  = FRAME_BITS'(r_win_start);
                        end
                    end else if (r_delta[DLT_W-1]) begin
                        // Backward step
                        if ($signed(r_next) >= $signed(w_start_x)) begin
                            n_pos = r_next[FRAME_BITS-1:0];
                        end else if (r_loop) begin
                            w_div_ctl.start = 1'b1;
                            w_div_ctl.count = CNT_W'(DIV_W);
                            w_div_dvd       = w_bwd_dvd[DIV_W-1:0];
                            w_div_dsr       = DIV_W'(r_win_len);
                            n_bwd           = 1'b1;
                            n_state         = S_MOD;
                        end else begin
                            n_live = 1'b1;
                            n_pos  = FRAME_BITS'(r_win_start);
                        end
                    end
                end
            end
            S_MOD: begin
                // Wrap by the remainder; zero remainder going back lands on start
                if (w_div_sts.done) begin
                    if (!r_bwd) begin
                        n_pos = w_fwd_pos[FRAME_BITS-1:0];
                    end else if (w_rem == '0) begin
                        n_pos = FRAME_BITS'(r_win_start);
                    end else begin
                        n_pos = w_bwd_pos[FRAME_BITS-1:0];
                    end
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_pos[M_TDATA_W-1:0];
                    n_out_live  = r_live;
                    n_out_moved = r_moved;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload, no reset
    always_ff @(posedge i_clk) begin
        r_delta     <= n_delta;
        r_neg       <= n_neg;
        r_next      <= n_next;
        r_end       <= n_end;
        r_bwd       <= n_bwd;
        r_live      <= n_live;
        r_moved     <= n_moved;
        r_out_pos   <= n_out_pos;
        r_out_live  <= n_out_live;
        r_out_moved <= n_out_moved;
    end

    pfps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_sts      (w_div_sts),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pos;
    assign m_axis_tuser  = {r_out_moved, r_out_live};

    // Checks
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PDIV) || (r_state == S_MOD)) |-> (w_div_sts.busy || w_div_sts.done))
        else $error("waiting on divider that is not running");

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_sts.busy)
        else $error("divider busy while sequencer idle");

    a_live_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tuser[1])
        else $error("go_live without a step");

endmodule
